>>> hdl/unsigned_and_pointer_to_ascii_assert.svh
// Assertion macros for the binary to ASCII formatter.
// Included by the modules that check their own control logic.
`ifndef UNSIGNED_AND_POINTER_TO_ASCII_ASSERT_SVH
`define UNSIGNED_AND_POINTER_TO_ASCII_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define UPTOA_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("uptoa assertion failed");

// Next-cycle implication, disabled while reset is low.
`define UPTOA_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("uptoa assertion failed");

`endif

>>> hdl/uptoa_pkg.sv
// Package for the binary to ASCII formatter: payload types, sequencer states,
// character constants and lookup functions. No dependencies.
`default_nettype none

package uptoa_pkg;

  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned DEC_BITS = 32;
  localparam int unsigned BCD_DIGS = 10;
  localparam int unsigned BCD_W    = 4 * BCD_DIGS;
  localparam int unsigned HEX_DIGS = VALUE_W / 4;
  localparam int unsigned DAB_CNT_W = $clog2(DEC_BITS + 1);
  localparam int unsigned NDIG_W    = $clog2(HEX_DIGS + 1);

  localparam logic ACT_DEC = 1'b0;
  localparam logic ACT_PTR = 1'b1;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X    = 8'h78;

  localparam logic [2:0] NIL_LAST_IDX = 3'd4;

  typedef struct packed {
    logic                action;
    logic [VALUE_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAB,
    ST_SKIP,
    ST_PFX0,
    ST_PFX1,
    ST_EMIT,
    ST_NIL
  } state_t;

  // Digit to lowercase hex character ("0123456789abcdef").
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'b0, nib};
    end else begin
      c = 8'h57 + {4'b0, nib};
    end
    return c;
  endfunction

  // Characters of "(nil)".
  function automatic logic [7:0] nil_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6e;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6c;
      3'd4:    c = 8'h29;
      default: c = 8'h3f;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/unsigned_and_pointer_to_ascii.sv
// Top level of the binary to ASCII formatter (decimal and hex pointer text).
// Depends on uptoa_pkg, uptoa_dabble and the assertion macro header.
//
//   channel | handshake          | payload                   | direction
//   --------+--------------------+---------------------------+----------
//   request | start / busy       | in_req  (action, value)   | in
//   result  | out_valid (strobe) | out_res (char_out, last)  | out
//
// A request is taken when start is high and busy is low; busy stays high
// until the last character of that request has been issued.
// Decimal: the dabble unit runs 32 shifts, one bit per cycle, then raises
// done; then come leading-zero skips and characters, which add up to ten.
// Pointer: skips, then "0x", then digits; skips and digits add up to 16.
// A zero pointer gives "(nil)" instead. The skip shifts the digits one
// nibble per cycle.
// Reset is synchronous and clears the sequencer; results cannot be stalled.
`default_nettype none
`include "unsigned_and_pointer_to_ascii_assert.svh"

module unsigned_and_pointer_to_ascii (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire uptoa_pkg::in_req_t in_req,
  output logic                    out_valid,
  output uptoa_pkg::out_res_t     out_res
);

  localparam int unsigned DW = uptoa_pkg::VALUE_W;

  uptoa_pkg::state_t               state_r, state_nxt;
  logic [DW-1:0]                   digits_r, digits_nxt;
  logic [uptoa_pkg::NDIG_W-1:0]    ndig_r, ndig_nxt;
  logic                            hex_r, hex_nxt;
  logic                            out_valid_r, out_valid_nxt;
  uptoa_pkg::out_res_t             out_res_r, out_res_nxt;

  logic                            dab_go;
  logic                            dab_done;
  logic [uptoa_pkg::BCD_W-1:0]     dab_bcd;
  logic                            top_zero;

  uptoa_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (dab_go),
    .bin   (in_req.value[uptoa_pkg::DEC_BITS-1:0]),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  assign top_zero = (digits_r[DW-1 -: 4] == 4'd0);

  always_comb begin
    state_nxt     = state_r;
    digits_nxt    = digits_r;
    ndig_nxt      = ndig_r;
    hex_nxt       = hex_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    dab_go        = 1'b0;

    case (state_r)
      uptoa_pkg::ST_IDLE: begin
        // Take a request; pointer zero goes straight to "(nil)".
        if (start) begin
          if (in_req.action == uptoa_pkg::ACT_PTR) begin
            hex_nxt = 1'b1;
            if (in_req.value == '0) begin
              ndig_nxt  = '0;
              state_nxt = uptoa_pkg::ST_NIL;
            end else begin
              digits_nxt = in_req.value;
              ndig_nxt   = uptoa_pkg::NDIG_W'(uptoa_pkg::HEX_DIGS);
              state_nxt  = uptoa_pkg::ST_SKIP;
            end
          end else begin
            hex_nxt   = 1'b0;
            dab_go    = 1'b1;
            state_nxt = uptoa_pkg::ST_DAB;
          end
        end
      end

      uptoa_pkg::ST_DAB: begin
        // Wait for BCD; left-align the ten decimal digits.
        if (dab_done) begin
          digits_nxt = {dab_bcd, {(DW - uptoa_pkg::BCD_W){1'b0}}};
          ndig_nxt   = uptoa_pkg::NDIG_W'(uptoa_pkg::BCD_DIGS);
          state_nxt  = uptoa_pkg::ST_SKIP;
        end
      end

      uptoa_pkg::ST_SKIP: begin
        // Drop leading zero digits, keeping at least one.
        if (top_zero && ndig_r > uptoa_pkg::NDIG_W'(1)) begin
          digits_nxt = {digits_r[DW-5:0], 4'd0};
          ndig_nxt   = ndig_r - 1'b1;
        end else if (hex_r) begin
          state_nxt = uptoa_pkg::ST_PFX0;
        end else begin
          state_nxt = uptoa_pkg::ST_EMIT;
        end
      end

      uptoa_pkg::ST_PFX0: begin
        out_valid_nxt        = 1'b1;
        out_res_nxt.char_out = uptoa_pkg::CH_ZERO;
        out_res_nxt.last     = 1'b0;
        state_nxt            = uptoa_pkg::ST_PFX1;
      end

      uptoa_pkg::ST_PFX1: begin
        out_valid_nxt        = 1'b1;
        out_res_nxt.char_out = uptoa_pkg::CH_X;
        out_res_nxt.last     = 1'b0;
        state_nxt            = uptoa_pkg::ST_EMIT;
      end

      uptoa_pkg::ST_EMIT: begin
        // Issue the top digit and advance to the next one.
        out_valid_nxt        = 1'b1;
        out_res_nxt.char_out = uptoa_pkg::hex_char(digits_r[DW-1 -: 4]);
        out_res_nxt.last     = (ndig_r == uptoa_pkg::NDIG_W'(1));
        digits_nxt           = {digits_r[DW-5:0], 4'd0};
        ndig_nxt             = ndig_r - 1'b1;
        if (ndig_r == uptoa_pkg::NDIG_W'(1)) begin
          state_nxt = uptoa_pkg::ST_IDLE;
        end
      end

      uptoa_pkg::ST_NIL: begin
        out_valid_nxt        = 1'b1;
        out_res_nxt.char_out = uptoa_pkg::nil_char(ndig_r[2:0]);
        out_res_nxt.last     = (ndig_r[2:0] == uptoa_pkg::NIL_LAST_IDX);
        ndig_nxt             = ndig_r + 1'b1;
        if (ndig_r[2:0] == uptoa_pkg::NIL_LAST_IDX) begin
          state_nxt = uptoa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = uptoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uptoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    digits_r  <= digits_nxt;
    ndig_r    <= ndig_nxt;
    hex_r     <= hex_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != uptoa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `UPTOA_ASSERT_NXT(a_accept_quiet, clk, rst_n, start && !busy, !out_valid)
  `UPTOA_ASSERT_IMP(a_last_frees, clk, rst_n, out_valid && out_res.last, !busy)
  `UPTOA_ASSERT_IMP(a_done_in_dab, clk, rst_n, dab_done, state_r == uptoa_pkg::ST_DAB)
  `UPTOA_ASSERT_IMP(a_skip_ndig, clk, rst_n, state_r == uptoa_pkg::ST_SKIP, ndig_r != '0)

endmodule

`default_nettype wire

>>> hdl/uptoa_dabble.sv
// Iterative binary to BCD converter (double dabble, one bit per cycle).
// Depends on uptoa_pkg and the assertion macro header.
`default_nettype none
`include "unsigned_and_pointer_to_ascii_assert.svh"

module uptoa_dabble (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          go,
  input  wire logic [uptoa_pkg::DEC_BITS-1:0] bin,
  output logic                               done,
  output logic [uptoa_pkg::BCD_W-1:0]        bcd
);

  logic [uptoa_pkg::DEC_BITS-1:0]  bin_r, bin_nxt;
  logic [uptoa_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [uptoa_pkg::DAB_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                            run_r, run_nxt;
  logic                            done_r, done_nxt;
  logic [uptoa_pkg::BCD_W-1:0]     adj;

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < uptoa_pkg::BCD_DIGS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      bin_nxt = bin;
      bcd_nxt = '0;
      cnt_nxt = uptoa_pkg::DAB_CNT_W'(uptoa_pkg::DEC_BITS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = {adj[uptoa_pkg::BCD_W-2:0], bin_r[uptoa_pkg::DEC_BITS-1]};
      bin_nxt = {bin_r[uptoa_pkg::DEC_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == uptoa_pkg::DAB_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

  `UPTOA_ASSERT_NXT(a_go_runs, clk, rst_n, go, run_r)
  `UPTOA_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !run_r)
  `UPTOA_ASSERT_IMP(a_run_cnt, clk, rst_n, run_r, cnt_r != '0)

endmodule

`default_nettype wire
